// ===== sv/segment_intersection_test_assert.svh =====
// assertion macros used by the checker file
`ifndef SEGMENT_INTERSECTION_TEST_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SIT_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment intersection check failed");

// next-cycle implication, checked outside reset
`define SIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment intersection check failed");

`endif

// ===== sv/sit_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sit_pkg;

  // coordinate width and the exact widths of the derived quantities
  localparam int COORD_WIDTH = 16;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
  localparam int CROSS_WIDTH = PROD_WIDTH + 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [CROSS_WIDTH-1:0] cross_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } seg_pair_t;

  typedef enum logic [1:0] {
    REL_MISS      = 2'd0,
    REL_MEET      = 2'd1,
    REL_PARALLEL  = 2'd2,
    REL_COLLINEAR = 2'd3
  } rel_t;

  typedef struct packed {
    logic meets;
    rel_t relation;
  } result_t;

  // partial products of the three cross products, plus the span checks
  typedef struct packed {
    prod_t rx_sy;
    prod_t ry_sx;
    prod_t wx_sy;
    prod_t wy_sx;
    prod_t wx_ry;
    prod_t wy_rx;
    logic  x_overlap;
    logic  y_overlap;
  } prod_set_t;

endpackage

`default_nettype wire

// ===== sv/sit_decide.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sit_decide (
  input  wire sit_pkg::prod_set_t prods,
  output sit_pkg::result_t        result
);

  // signed zero, so the ordering compares below stay signed
  localparam sit_pkg::cross_t CROSS_ZERO = '0;

  sit_pkg::cross_t d;
  sit_pkg::cross_t tn;
  sit_pkg::cross_t un;
  logic            d_pos;
  logic            t_in;
  logic            u_in;
  logic            hit;

  // cross products, sign extended one bit so the difference is exact
  assign d  = {prods.rx_sy[sit_pkg::PROD_WIDTH-1], prods.rx_sy}
            - {prods.ry_sx[sit_pkg::PROD_WIDTH-1], prods.ry_sx};
  assign tn = {prods.wx_sy[sit_pkg::PROD_WIDTH-1], prods.wx_sy}
            - {prods.wy_sx[sit_pkg::PROD_WIDTH-1], prods.wy_sx};
  assign un = {prods.wx_ry[sit_pkg::PROD_WIDTH-1], prods.wx_ry}
            - {prods.wy_rx[sit_pkg::PROD_WIDTH-1], prods.wy_rx};

  assign d_pos = (d > CROSS_ZERO);

  // parameter in [0,1] without dividing: compare numerator against d
  assign t_in = d_pos ? ((tn >= CROSS_ZERO) && (tn <= d))
                      : ((tn <= CROSS_ZERO) && (tn >= d));
  assign u_in = d_pos ? ((un >= CROSS_ZERO) && (un <= d))
                      : ((un <= CROSS_ZERO) && (un >= d));
  assign hit  = t_in && u_in;

  always_comb begin
    priority if (d != '0) begin
      result.meets    = hit;
      result.relation = hit ? sit_pkg::REL_MEET : sit_pkg::REL_MISS;
    end else if ((tn == '0) && (un == '0)) begin
      result.meets    = prods.x_overlap && prods.y_overlap;
      result.relation = sit_pkg::REL_COLLINEAR;
    end else begin
      result.meets    = 1'b0;
      result.relation = sit_pkg::REL_PARALLEL;
    end
  end

endmodule

`default_nettype wire

// ===== sv/segment_intersection_test.sv =====
// segment intersection test: one result beat per segment-pair beat
// the beat is registered in the input register, then in the result register
// one beat per cycle when not stalled; path: subtract, 17x17 multiply, subtract, compare
// the input register holds its beat while the result register is full and stalled
// reset (rst, synchronous) empties both registers; the block keeps no other state
`timescale 1ns / 1ps
`default_nettype none

module segment_intersection_test (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   seg_valid,
  output logic                  seg_ready,
  input  wire sit_pkg::seg_pair_t seg,
  output logic                  res_valid,
  input  wire                   res_ready,
  output sit_pkg::result_t      res
);

  // input register
  sit_pkg::seg_pair_t s1;
  logic               s1_valid;

  // products and span checks for the held pair
  sit_pkg::prod_set_t prods;

  // result room: the result register can load when empty or when it drains
  logic               res_room;

  // direction vectors r, s and the start offset w = q - p
  sit_pkg::diff_t     rx, ry, sx, sy, wx, wy;

  // interval bounds for the collinear overlap test
  sit_pkg::coord_t    ax_lo, ax_hi, bx_lo, bx_hi;
  sit_pkg::coord_t    ay_lo, ay_hi, by_lo, by_hi;

  sit_pkg::result_t   decided;

  assign res_room  = !res_valid || res_ready;
  assign seg_ready = !s1_valid || res_room;

  // differences are one bit wider than the coordinates, so they stay exact
  assign rx = {s1.a_end_x[sit_pkg::COORD_WIDTH-1], s1.a_end_x}
            - {s1.a_start_x[sit_pkg::COORD_WIDTH-1], s1.a_start_x};
  assign ry = {s1.a_end_y[sit_pkg::COORD_WIDTH-1], s1.a_end_y}
            - {s1.a_start_y[sit_pkg::COORD_WIDTH-1], s1.a_start_y};
  assign sx = {s1.b_end_x[sit_pkg::COORD_WIDTH-1], s1.b_end_x}
            - {s1.b_start_x[sit_pkg::COORD_WIDTH-1], s1.b_start_x};
  assign sy = {s1.b_end_y[sit_pkg::COORD_WIDTH-1], s1.b_end_y}
            - {s1.b_start_y[sit_pkg::COORD_WIDTH-1], s1.b_start_y};
  assign wx = {s1.b_start_x[sit_pkg::COORD_WIDTH-1], s1.b_start_x}
            - {s1.a_start_x[sit_pkg::COORD_WIDTH-1], s1.a_start_x};
  assign wy = {s1.b_start_y[sit_pkg::COORD_WIDTH-1], s1.b_start_y}
            - {s1.a_start_y[sit_pkg::COORD_WIDTH-1], s1.a_start_y};

  // closed intervals of each segment on both axes
  assign ax_lo = (s1.a_start_x < s1.a_end_x) ? s1.a_start_x : s1.a_end_x;
  assign ax_hi = (s1.a_start_x < s1.a_end_x) ? s1.a_end_x   : s1.a_start_x;
  assign bx_lo = (s1.b_start_x < s1.b_end_x) ? s1.b_start_x : s1.b_end_x;
  assign bx_hi = (s1.b_start_x < s1.b_end_x) ? s1.b_end_x   : s1.b_start_x;
  assign ay_lo = (s1.a_start_y < s1.a_end_y) ? s1.a_start_y : s1.a_end_y;
  assign ay_hi = (s1.a_start_y < s1.a_end_y) ? s1.a_end_y   : s1.a_start_y;
  assign by_lo = (s1.b_start_y < s1.b_end_y) ? s1.b_start_y : s1.b_end_y;
  assign by_hi = (s1.b_start_y < s1.b_end_y) ? s1.b_end_y   : s1.b_start_y;

  // six independent signed multiplies, side by side
  always_comb begin
    prods.rx_sy     = rx * sy;
    prods.ry_sx     = ry * sx;
    prods.wx_sy     = wx * sy;
    prods.wy_sx     = wy * sx;
    prods.wx_ry     = wx * ry;
    prods.wy_rx     = wy * rx;
    prods.x_overlap = (ax_lo <= bx_hi) && (bx_lo <= ax_hi);
    prods.y_overlap = (ay_lo <= by_hi) && (by_lo <= ay_hi);
  end

  // cross-product subtracts and the final classification
  sit_decide u_decide (
    .prods  (prods),
    .result (decided)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (seg_ready) begin
        s1_valid <= seg_valid;
      end
      if (res_room) begin
        res_valid <= s1_valid;
      end
    end
  end

  // payload registers load only when a beat moves in
  always_ff @(posedge clk) begin
    if (seg_valid && seg_ready) begin
      s1 <= seg;
    end
    if (s1_valid && res_room) begin
      res <= decided;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sit_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "segment_intersection_test_assert.svh"

module sit_checker (
  input wire                     clk,
  input wire                     rst,
  input wire                     seg_valid,
  input wire                     seg_ready,
  input wire sit_pkg::seg_pair_t seg,
  input wire                     res_valid,
  input wire                     res_ready,
  input wire sit_pkg::result_t   res
);

  logic parallel;

  assign parallel = (res.relation == sit_pkg::REL_PARALLEL);

  // a stalled input beat holds
  `SIT_ASSERT_NEXT(a_seg_hold, seg_valid && !seg_ready, seg_valid && $stable(seg))

  // a stalled result beat holds
  `SIT_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))

  // parallel distinct segments never meet
  `SIT_ASSERT_IMPLIES(a_parallel_miss, res_valid && parallel, !res.meets)

  // an empty output means the block can take a beat
  `SIT_ASSERT_IMPLIES(a_ready_when_empty, !res_valid, seg_ready)

  // leaving reset: nothing pending and input open
  `SIT_ASSERT_IMPLIES(a_reset_clean, $past(rst), !res_valid && seg_ready)

endmodule

bind segment_intersection_test sit_checker u_sit_checker (.*);

`default_nettype wire

// ===== sim/tb_segment_intersection_test.sv =====
`timescale 1ns / 1ps

module tb_segment_intersection_test;

  // run limit, far above the slowest legal run (~900 beats)
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_PAIRS = 850;
  localparam int MAX_WAIT     = 8;
  localparam int DRAIN_CYCLES = 8;

  // one directed stimulus row; want is only used when typed is set
  typedef struct {
    sit_pkg::seg_pair_t pair;
    bit                 typed;
    sit_pkg::result_t   want;
  } seg_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               seg_valid = 1'b0;
  logic               seg_ready;
  sit_pkg::seg_pair_t seg = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  sit_pkg::result_t   res;

  // expectation that travels alongside the segment pair being offered
  sit_pkg::result_t   seg_want = '0;
  sit_pkg::result_t   want_q[$];
  seg_row_t           directed_rows[$];

  int  cycles = 0;
  int  errors = 0;
  int  checked = 0;
  int  rel_seen[4] = '{0, 0, 0, 0};
  int  directed_sent = 0;
  int  random_sent = 0;
  // when set, neither side inserts gaps or stalls
  bit  calm = 1'b0;

  segment_intersection_test dut (
    .clk      (clk),
    .rst      (rst),
    .seg_valid(seg_valid),
    .seg_ready(seg_ready),
    .seg      (seg),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // intersection predictor: exact 64-bit integer arithmetic on the coordinates
  // ---------------------------------------------------------------------------

  // parameter n / d inside the closed unit interval, without division
  function automatic bit within_unit(longint n, longint d);
    if (d > 0) return (n >= 0) && (n <= d);
    return (n <= 0) && (n >= d);
  endfunction

  // closed interval overlap of [a0,a1] and [b0,b1] in any endpoint order
  function automatic bit spans_overlap(longint a0, longint a1, longint b0, longint b1);
    longint alo, ahi, blo, bhi;
    alo = (a0 < a1) ? a0 : a1;
    ahi = (a0 < a1) ? a1 : a0;
    blo = (b0 < b1) ? b0 : b1;
    bhi = (b0 < b1) ? b1 : b0;
    return (alo <= bhi) && (blo <= ahi);
  endfunction

  function automatic sit_pkg::result_t predict_intersection(sit_pkg::seg_pair_t p);
    longint px, py, ex, ey, qx, qy, fx, fy;
    longint rx, ry, sx, sy, wx, wy;
    longint den, t_num, u_num;
    sit_pkg::result_t r;
    // coord_t is signed, so the casts sign-extend
    px = longint'(p.a_start_x);
    py = longint'(p.a_start_y);
    ex = longint'(p.a_end_x);
    ey = longint'(p.a_end_y);
    qx = longint'(p.b_start_x);
    qy = longint'(p.b_start_y);
    fx = longint'(p.b_end_x);
    fy = longint'(p.b_end_y);
    rx = ex - px;
    ry = ey - py;
    sx = fx - qx;
    sy = fy - qy;
    wx = qx - px;
    wy = qy - py;
    den   = rx * sy - ry * sx;
    t_num = wx * sy - wy * sx;
    u_num = wx * ry - wy * rx;
    if (den != 0) begin
      // lines cross: both parameters must land on their segments
      r.meets    = within_unit(t_num, den) && within_unit(u_num, den);
      r.relation = r.meets ? sit_pkg::REL_MEET : sit_pkg::REL_MISS;
    end else if (t_num == 0 && u_num == 0) begin
      // all four points on one line: fall back to the bounding spans
      r.relation = sit_pkg::REL_COLLINEAR;
      r.meets    = spans_overlap(px, ex, qx, fx) && spans_overlap(py, ey, qy, fy);
    end else begin
      r.relation = sit_pkg::REL_PARALLEL;
      r.meets    = 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int draw_wait();
    if (calm) return 0;
    return int'($urandom_range(MAX_WAIT));
  endfunction

  function automatic int pick(int lo, int hi);
    return int'($urandom_range(hi - lo)) + lo;
  endfunction

  function automatic void add_row(int ax0, int ay0, int ax1, int ay1,
                                  int bx0, int by0, int bx1, int by1,
                                  bit typed, bit m, sit_pkg::rel_t rel);
    seg_row_t row;
    row.pair.a_start_x = sit_pkg::coord_t'(ax0);
    row.pair.a_start_y = sit_pkg::coord_t'(ay0);
    row.pair.a_end_x   = sit_pkg::coord_t'(ax1);
    row.pair.a_end_y   = sit_pkg::coord_t'(ay1);
    row.pair.b_start_x = sit_pkg::coord_t'(bx0);
    row.pair.b_start_y = sit_pkg::coord_t'(by0);
    row.pair.b_end_x   = sit_pkg::coord_t'(bx1);
    row.pair.b_end_y   = sit_pkg::coord_t'(by1);
    row.typed          = typed;
    row.want.meets     = m;
    row.want.relation  = rel;
    directed_rows.push_back(row);
  endfunction

  // random segment pair, shaped so that every relation shows up often
  function automatic sit_pkg::seg_pair_t make_random_pair();
    sit_pkg::seg_pair_t p;
    int kind, bx, by, dx, dy, ox, oy, ka, kb, kc, kd;
    int cx, cy, ex, ey;
    kind = int'($urandom_range(9));
    case (kind)
      0, 1: begin
        // full range, every bit of every field free
        p = sit_pkg::seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
      end
      2, 3: begin
        // tiny box, lots of accidental touching and collinear pairs
        p.a_start_x = sit_pkg::coord_t'(pick(-8, 8));
        p.a_start_y = sit_pkg::coord_t'(pick(-8, 8));
        p.a_end_x   = sit_pkg::coord_t'(pick(-8, 8));
        p.a_end_y   = sit_pkg::coord_t'(pick(-8, 8));
        p.b_start_x = sit_pkg::coord_t'(pick(-8, 8));
        p.b_start_y = sit_pkg::coord_t'(pick(-8, 8));
        p.b_end_x   = sit_pkg::coord_t'(pick(-8, 8));
        p.b_end_y   = sit_pkg::coord_t'(pick(-8, 8));
      end
      4, 5, 6, 7: begin
        // points on one line; kind 6 shifts b off it (parallel),
        // kind 7 collapses a to a point, sometimes b too, and may shift b off
        bx = pick(-1000, 1000);
        by = pick(-1000, 1000);
        dx = pick(-20, 20);
        dy = pick(-20, 20);
        ka = pick(-30, 30);
        kb = pick(-30, 30);
        kc = pick(-30, 30);
        kd = pick(-30, 30);
        ox = 0;
        oy = 0;
        if (kind == 6 || (kind == 7 && $urandom_range(2) == 0)) begin
          ox = pick(-5, 5);
          oy = pick(-5, 5);
        end
        if (kind == 7) begin
          kb = ka;
          if ($urandom_range(1) == 0) kd = kc;
        end
        p.a_start_x = sit_pkg::coord_t'(bx + ka * dx);
        p.a_start_y = sit_pkg::coord_t'(by + ka * dy);
        p.a_end_x   = sit_pkg::coord_t'(bx + kb * dx);
        p.a_end_y   = sit_pkg::coord_t'(by + kb * dy);
        p.b_start_x = sit_pkg::coord_t'(bx + ox + kc * dx);
        p.b_start_y = sit_pkg::coord_t'(by + oy + kc * dy);
        p.b_end_x   = sit_pkg::coord_t'(bx + ox + kd * dx);
        p.b_end_y   = sit_pkg::coord_t'(by + oy + kd * dy);
      end
      8: begin
        // b starts on one of a's endpoints
        p.a_start_x = sit_pkg::coord_t'(pick(-3000, 3000));
        p.a_start_y = sit_pkg::coord_t'(pick(-3000, 3000));
        p.a_end_x   = sit_pkg::coord_t'(pick(-3000, 3000));
        p.a_end_y   = sit_pkg::coord_t'(pick(-3000, 3000));
        p.b_start_x = $urandom_range(1) ? p.a_start_x : p.a_end_x;
        p.b_start_y = (p.b_start_x == p.a_start_x) ? p.a_start_y : p.a_end_y;
        p.b_end_x   = sit_pkg::coord_t'(pick(-3000, 3000));
        p.b_end_y   = sit_pkg::coord_t'(pick(-3000, 3000));
      end
      default: begin
        // two lines through a common point, ends straddling it or not
        cx = pick(-2000, 2000);
        cy = pick(-2000, 2000);
        dx = pick(-30, 30);
        dy = pick(-30, 30);
        ex = pick(-30, 30);
        ey = pick(-30, 30);
        ka = pick(-5, 40);
        kb = pick(-5, 40);
        kc = pick(-5, 40);
        kd = pick(-5, 40);
        p.a_start_x = sit_pkg::coord_t'(cx - ka * dx);
        p.a_start_y = sit_pkg::coord_t'(cy - ka * dy);
        p.a_end_x   = sit_pkg::coord_t'(cx + kb * dx);
        p.a_end_y   = sit_pkg::coord_t'(cy + kb * dy);
        p.b_start_x = sit_pkg::coord_t'(cx - kc * ex);
        p.b_start_y = sit_pkg::coord_t'(cy - kc * ey);
        p.b_end_x   = sit_pkg::coord_t'(cx + kd * ex);
        p.b_end_y   = sit_pkg::coord_t'(cy + kd * ey);
      end
    endcase
    return p;
  endfunction

  // offer one beat after a random gap and hold it until taken;
  // returns at the falling edge after the accepting rising edge
  task automatic send_pair(sit_pkg::seg_pair_t p, sit_pkg::result_t want);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      seg_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    seg       <= p;
    seg_want  <= want;
    seg_valid <= 1'b1;
    @(posedge clk);
    while (!seg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // cycle counter and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, want_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: record accepted input beats, check accepted result beats
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sit_pkg::result_t want;
    if (!rst) begin
      if (seg_valid && seg_ready) want_q.push_back(seg_want);
      if (res_valid && res_ready) begin
        if (want_q.size() == 0) begin
          report_mismatch($sformatf("result beat meets=%0b relation=%0d with nothing due",
                                    res.meets, res.relation));
        end else begin
          want = want_q.pop_front();
          checked++;
          rel_seen[res.relation]++;
          if (res.meets !== want.meets)
            report_mismatch($sformatf("meets %0b, expected %0b", res.meets, want.meets));
          if (res.relation !== want.relation)
            report_mismatch($sformatf("relation %0d, expected %0d",
                                      res.relation, want.relation));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random stall before each beat, none while calm
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ready <= 1'b1;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    seg_row_t row;
    sit_pkg::seg_pair_t p;

    // directed rows: corners of the coordinate range, each relation,
    // touching ends, degenerate point segments
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 1'b1, sit_pkg::REL_COLLINEAR);
    add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
            1, 1'b1, sit_pkg::REL_COLLINEAR);
    add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
            1, 1'b1, sit_pkg::REL_COLLINEAR);
    add_row(0, 0, 0, 0, 1, 1, 1, 1, 1, 1'b0, sit_pkg::REL_COLLINEAR);
    add_row(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768,
            0, 1'b0, sit_pkg::REL_MISS);
    add_row(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768,
            0, 1'b0, sit_pkg::REL_MISS);
    add_row(-32768, 0, 32767, 0, 32767, 0, -32768, 0, 1, 1'b1, sit_pkg::REL_COLLINEAR);
    add_row(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767,
            1, 1'b0, sit_pkg::REL_PARALLEL);
    // ends touching, t-junction, clear miss
    add_row(0, 0, 10, 0, 10, 0, 10, 10, 0, 1'b0, sit_pkg::REL_MISS);
    add_row(0, 0, 10, 0, 5, 0, 5, 10, 0, 1'b0, sit_pkg::REL_MISS);
    add_row(0, 0, 10, 0, 20, -5, 20, 5, 0, 1'b0, sit_pkg::REL_MISS);
    // crossing with positive and negative denominator, and a near miss
    add_row(0, 0, 10, 10, 10, 0, 0, 10, 0, 1'b0, sit_pkg::REL_MISS);
    add_row(0, 0, 10, 10, 0, 10, 10, 0, 0, 1'b0, sit_pkg::REL_MISS);
    add_row(0, 0, 10, 10, 0, 30, 30, 0, 0, 1'b0, sit_pkg::REL_MISS);
    // parallel and collinear cases
    add_row(0, 0, 10, 0, 0, 5, 10, 5, 1, 1'b0, sit_pkg::REL_PARALLEL);
    add_row(0, 0, 10, 10, 5, 5, 20, 20, 1, 1'b1, sit_pkg::REL_COLLINEAR);
    add_row(0, 0, 10, 10, 11, 11, 20, 20, 1, 1'b0, sit_pkg::REL_COLLINEAR);
    add_row(0, 0, 10, 10, 10, 10, 20, 20, 1, 1'b1, sit_pkg::REL_COLLINEAR);
    add_row(0, 0, 0, 10, 0, 11, 0, 20, 1, 1'b0, sit_pkg::REL_COLLINEAR);
    // point segments: on, off the line, on the line but past the end
    add_row(5, 0, 5, 0, 0, 0, 10, 0, 1, 1'b1, sit_pkg::REL_COLLINEAR);
    add_row(5, 3, 5, 3, 0, 0, 10, 0, 1, 1'b0, sit_pkg::REL_PARALLEL);
    add_row(20, 0, 20, 0, 0, 0, 10, 0, 1, 1'b0, sit_pkg::REL_COLLINEAR);
    add_row(0, 0, 10, 10, 3, 3, 3, 3, 1, 1'b1, sit_pkg::REL_COLLINEAR);

    // reset held from time zero, released on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_pair(row.pair, row.typed ? row.want : predict_intersection(row.pair));
      directed_sent++;
    end

    // random pairs, with calm stretches where both sides run flat out
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n % 64 == 0) calm = ($urandom_range(3) == 0);
      p = make_random_pair();
      send_pair(p, predict_intersection(p));
      random_sent++;
    end
    seg_valid <= 1'b0;

    // drain, then keep watching for stray result beats
    while (want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d directed and %0d random segment pairs, checked %0d results",
             directed_sent, random_sent, checked);
    $display("relations seen: miss %0d, meet %0d, parallel %0d, collinear %0d",
             rel_seen[sit_pkg::REL_MISS], rel_seen[sit_pkg::REL_MEET],
             rel_seen[sit_pkg::REL_PARALLEL], rel_seen[sit_pkg::REL_COLLINEAR]);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== segment_intersection_test.f =====
+incdir+sv
sv/sit_pkg.sv
sv/sit_decide.sv
sv/segment_intersection_test.sv
sv/sit_checker.sv
sim/tb_segment_intersection_test.sv
